>>> rtl/core/rns_pkg.sv
`timescale 1ns / 1ps

package rns_pkg;

  localparam int MaxDim   = 4096;
  localparam int CoordW   = $clog2(MaxDim);
  localparam int DimW     = CoordW + 1;
  localparam int TrigW    = 18;
  localparam int BaseW    = 32;
  localparam int PitchW   = 15;
  localparam int BppW     = 3;
  localparam int OffsW    = 26;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int ProdW    = TrigW + CoordW + 1;
  localparam int PosW     = BaseW + 2;
  localparam int IntW     = PosW - FracW;
  localparam int RowOffW  = CoordW + PitchW;
  localparam int ColOffW  = CoordW + BppW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 3'd0,
    CfgSrcHeight = 3'd1,
    CfgSin       = 3'd2,
    CfgCos       = 3'd3,
    CfgXBase     = 3'd4,
    CfgYBase     = 3'd5,
    CfgRowPitch  = 3'd6,
    CfgBpp       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]         src_width;
    logic [DimW-1:0]         src_height;
    logic signed [TrigW-1:0] sin_q16;
    logic signed [TrigW-1:0] cos_q16;
    logic signed [BaseW-1:0] x_base;
    logic signed [BaseW-1:0] y_base;
    logic [PitchW-1:0]       row_pitch;
    logic [BppW-1:0]         bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
  } pos_t;

endpackage

>>> rtl/core/rns_if.sv
`timescale 1ns / 1ps

interface rns_in_if;
  logic                      valid;
  logic                      ready;
  logic [rns_pkg::CoordW-1:0] dest_col;
  logic [rns_pkg::CoordW-1:0] dest_row;
  modport source (output valid, output dest_col, output dest_row, input ready);
  modport sink (input valid, input dest_col, input dest_row, output ready);
endinterface

interface rns_out_if;
  logic                      valid;
  logic                      ready;
  logic                      use_background;
  logic [rns_pkg::CoordW-1:0] src_col;
  logic [rns_pkg::CoordW-1:0] src_row;
  logic [rns_pkg::OffsW-1:0]  byte_offset;
  modport source (output valid, output use_background, output src_col, output src_row,
                  output byte_offset, input ready);
  modport sink (input valid, input use_background, input src_col, input src_row,
                input byte_offset, output ready);
endinterface

interface rns_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rns_pkg::CfgIdxW-1:0]  index;
  logic [rns_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rotate_nearest_source_address.sv
// Throughput: one beat per cycle while the output channel is ready; the four registered
// stages each hold one beat.
// Stages: Q16 products, position sums, range check with offset products, output register.
// Reset: asynchronous and active low; it empties the pipeline and loads the register
// defaults (1x1 source, zero angle, zero bases, pitch 4096, four bytes per pixel).
`timescale 1ns / 1ps

module rotate_nearest_source_address (
  input  logic         clk_i,
  input  logic         rst_ni,
  rns_cfg_if.sink      cfg_i,
  rns_in_if.sink       in_i,
  rns_out_if.source    out_o
);

  rns_pkg::cfg_t cfg;
  logic          pos_valid, pos_ready;
  rns_pkg::pos_t pos;

  rns_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  rns_pos u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_i.valid),
    .col_i   (in_i.dest_col),
    .row_i   (in_i.dest_row),
    .ready_o (in_i.ready),
    .valid_o (pos_valid),
    .pos_o   (pos),
    .ready_i (pos_ready)
  );

  rns_addr u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (pos_valid),
    .pos_i            (pos),
    .ready_o          (pos_ready),
    .valid_o          (out_o.valid),
    .use_background_o (out_o.use_background),
    .src_col_o        (out_o.src_col),
    .src_row_o        (out_o.src_row),
    .byte_offset_o    (out_o.byte_offset),
    .ready_i          (out_o.ready)
  );

endmodule

>>> rtl/core/rns_cfg_regs.sv
`timescale 1ns / 1ps

module rns_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_valid_i,
  input  logic [rns_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [rns_pkg::CfgDataW-1:0] wr_data_i,
  output logic                         wr_ready_o,
  output rns_pkg::cfg_t                cfg_o
);

  rns_pkg::cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        rns_pkg::CfgSrcWidth:  cfg_d.src_width       = wr_data_i[rns_pkg::DimW-1:0];
        rns_pkg::CfgSrcHeight: cfg_d.src_height      = wr_data_i[rns_pkg::DimW-1:0];
        rns_pkg::CfgSin:       cfg_d.sin_q16         = wr_data_i[rns_pkg::TrigW-1:0];
        rns_pkg::CfgCos:       cfg_d.cos_q16         = wr_data_i[rns_pkg::TrigW-1:0];
        rns_pkg::CfgXBase:     cfg_d.x_base          = wr_data_i[rns_pkg::BaseW-1:0];
        rns_pkg::CfgYBase:     cfg_d.y_base          = wr_data_i[rns_pkg::BaseW-1:0];
        rns_pkg::CfgRowPitch:  cfg_d.row_pitch       = wr_data_i[rns_pkg::PitchW-1:0];
        rns_pkg::CfgBpp:       cfg_d.bytes_per_pixel = wr_data_i[rns_pkg::BppW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width       <= rns_pkg::DimW'(1);
      cfg_q.src_height      <= rns_pkg::DimW'(1);
      cfg_q.sin_q16         <= '0;
      cfg_q.cos_q16         <= rns_pkg::TrigW'(65536);
      cfg_q.x_base          <= '0;
      cfg_q.y_base          <= '0;
      cfg_q.row_pitch       <= rns_pkg::PitchW'(4096);
      cfg_q.bytes_per_pixel <= rns_pkg::BppW'(4);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/rns_pos.sv
`timescale 1ns / 1ps

module rns_pos (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rns_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  logic [rns_pkg::CoordW-1:0] col_i,
  input  logic [rns_pkg::CoordW-1:0] row_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output rns_pkg::pos_t              pos_o,
  input  logic                       ready_i
);

  localparam int ExtW = rns_pkg::PosW - rns_pkg::ProdW;
  localparam int BExtW = rns_pkg::PosW - rns_pkg::BaseW;
  localparam int TExtW = rns_pkg::ProdW - rns_pkg::TrigW;
  localparam int CExtW = rns_pkg::ProdW - rns_pkg::CoordW;

  logic                             s1_valid_q, s2_valid_q;
  logic                             s1_ready, s2_ready;
  logic signed [rns_pkg::ProdW-1:0] sin_x, cos_x, row_x, col_x;
  logic signed [rns_pkg::ProdW-1:0] sr_q, cr_q, cc_q, sc_q;
  logic signed [rns_pkg::ProdW-1:0] sr_d, cr_d, cc_d, sc_d;
  rns_pkg::pos_t                    pos_q, pos_d;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  always_comb begin
    sin_x = {{TExtW{cfg_i.sin_q16[rns_pkg::TrigW-1]}}, cfg_i.sin_q16};
    cos_x = {{TExtW{cfg_i.cos_q16[rns_pkg::TrigW-1]}}, cfg_i.cos_q16};
    row_x = {{CExtW{1'b0}}, row_i};
    col_x = {{CExtW{1'b0}}, col_i};
    sr_d = sin_x * row_x;
    cr_d = cos_x * row_x;
    cc_d = cos_x * col_x;
    sc_d = sin_x * col_x;
  end

  always_comb begin
    pos_d.px = $signed({{BExtW{cfg_i.x_base[rns_pkg::BaseW-1]}}, cfg_i.x_base})
             - $signed({{ExtW{sr_q[rns_pkg::ProdW-1]}}, sr_q})
             + $signed({{ExtW{cc_q[rns_pkg::ProdW-1]}}, cc_q});
    pos_d.py = $signed({{BExtW{cfg_i.y_base[rns_pkg::BaseW-1]}}, cfg_i.y_base})
             + $signed({{ExtW{cr_q[rns_pkg::ProdW-1]}}, cr_q})
             + $signed({{ExtW{sc_q[rns_pkg::ProdW-1]}}, sc_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      sr_q <= sr_d;
      cr_q <= cr_d;
      cc_q <= cc_d;
      sc_q <= sc_d;
    end
    if (s2_ready && s1_valid_q) begin
      pos_q <= pos_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign pos_o   = pos_q;

endmodule

>>> rtl/core/rns_addr.sv
`timescale 1ns / 1ps

module rns_addr (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rns_pkg::cfg_t               cfg_i,
  input  logic                        valid_i,
  input  rns_pkg::pos_t               pos_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output logic                        use_background_o,
  output logic [rns_pkg::CoordW-1:0]  src_col_o,
  output logic [rns_pkg::CoordW-1:0]  src_row_o,
  output logic [rns_pkg::OffsW-1:0]   byte_offset_o,
  input  logic                        ready_i
);

  localparam int UExtW = rns_pkg::IntW - rns_pkg::DimW;

  logic                        s3_valid_q, s4_valid_q;
  logic                        s3_ready, s4_ready;
  logic [rns_pkg::DimW-1:0]    w_lim, h_lim;
  logic [rns_pkg::IntW-1:0]    px_int, py_int;
  logic [rns_pkg::BppW-1:0]    pix_size;
  logic                        bg_d, bg_q, bg_out_q;
  logic [rns_pkg::CoordW-1:0]  col_d, row_d, col_q, row_q, col_out_q, row_out_q;
  logic [rns_pkg::RowOffW-1:0] row_off_d, row_off_q;
  logic [rns_pkg::ColOffW-1:0] col_off_d, col_off_q;
  logic [rns_pkg::RowOffW-1:0] off_sum;
  logic [rns_pkg::OffsW-1:0]   off_out_q;

  assign s4_ready = !s4_valid_q || ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  always_comb begin
    w_lim = (cfg_i.src_width > rns_pkg::DimW'(rns_pkg::MaxDim))
            ? rns_pkg::DimW'(rns_pkg::MaxDim) : cfg_i.src_width;
    h_lim = (cfg_i.src_height > rns_pkg::DimW'(rns_pkg::MaxDim))
            ? rns_pkg::DimW'(rns_pkg::MaxDim) : cfg_i.src_height;
    px_int = pos_i.px[rns_pkg::PosW-1:rns_pkg::FracW];
    py_int = pos_i.py[rns_pkg::PosW-1:rns_pkg::FracW];
    bg_d = pos_i.px[rns_pkg::PosW-1] || pos_i.py[rns_pkg::PosW-1]
        || (px_int >= {{UExtW{1'b0}}, w_lim}) || (py_int >= {{UExtW{1'b0}}, h_lim});
    col_d = px_int[rns_pkg::CoordW-1:0];
    row_d = py_int[rns_pkg::CoordW-1:0];
    case (cfg_i.bytes_per_pixel)
      rns_pkg::BppW'(1): pix_size = rns_pkg::BppW'(1);
      rns_pkg::BppW'(2): pix_size = rns_pkg::BppW'(2);
      rns_pkg::BppW'(4): pix_size = rns_pkg::BppW'(4);
      default:           pix_size = rns_pkg::BppW'(3);
    endcase
    row_off_d = {{rns_pkg::PitchW{1'b0}}, row_d}
              * {{rns_pkg::CoordW{1'b0}}, cfg_i.row_pitch};
    col_off_d = {{rns_pkg::BppW{1'b0}}, col_d} * {{rns_pkg::CoordW{1'b0}}, pix_size};
    off_sum   = row_off_q + {{(rns_pkg::RowOffW - rns_pkg::ColOffW){1'b0}}, col_off_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      bg_q      <= bg_d;
      col_q     <= col_d;
      row_q     <= row_d;
      row_off_q <= row_off_d;
      col_off_q <= col_off_d;
    end
    if (s4_ready && s3_valid_q) begin
      bg_out_q  <= bg_q;
      col_out_q <= bg_q ? '0 : col_q;
      row_out_q <= bg_q ? '0 : row_q;
      off_out_q <= bg_q ? '0 : off_sum[rns_pkg::OffsW-1:0];
    end
  end

  assign valid_o          = s4_valid_q;
  assign use_background_o = bg_out_q;
  assign src_col_o        = col_out_q;
  assign src_row_o        = row_out_q;
  assign byte_offset_o    = off_out_q;

  a_bg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && use_background_o |-> src_col_o == '0 && src_row_o == '0 && byte_offset_o == '0)
    else $error("background result carries a nonzero field");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !use_background_o |-> {1'b0, src_col_o} < w_lim && {1'b0, src_row_o} < h_lim)
    else $error("source coordinate outside the clamped extent");

  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_ready |=> s3_valid_q && $stable(bg_q) && $stable(col_q))
    else $error("stalled beat lost in the check stage");

  a_s4_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s4_ready |=> s4_valid_q)
    else $error("beat dropped between check and output stages");

endmodule

>>> bench/tb_rotate_nearest_source_address.sv
`timescale 1ns / 1ps

module tb_rotate_nearest_source_address;
  import rns_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int ResetCycles   = 7;
  localparam int NumPhases     = 14;
  localparam int ItemsPerPhase = 100;
  localparam int HoldCycles    = 300;
  localparam int WatchLimit    = 3000;
  localparam int DrainCycles   = 8;
  localparam int MaxReports    = 10;
  localparam int PressurePhase = 5;

  localparam longint Q16One  = longint'(1) << FracW;
  localparam longint BaseMax = (longint'(1) << (BaseW - 1)) - 1;
  localparam longint BaseMin = -(longint'(1) << (BaseW - 1));
  localparam longint TrigMin = -(longint'(1) << (TrigW - 1));

  typedef struct packed {
    logic              use_bg;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [OffsW-1:0]  offs;
  } pix_res_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   row;
    bit                  typed;
    pix_res_t            want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rns_cfg_if cfg_bus ();
  rns_in_if  in_bus ();
  rns_out_if out_bus ();

  rotate_nearest_source_address u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  cfg_t        cfg_mirror;
  pix_res_t    src_addr_q[$];
  int unsigned mism_cnt;
  bit          typed_pending;
  pix_res_t    typed_want;
  bit          idle_on;
  bit          hold_req;

  function automatic pix_res_t map_pixel(cfg_t k, logic [CoordW-1:0] col,
                                         logic [CoordW-1:0] row);
    longint s, c, px, py, xlim, ylim, size;
    longint unsigned offs;
    pix_res_t res;
    s = longint'($signed(k.sin_q16));
    c = longint'($signed(k.cos_q16));
    px = longint'($signed(k.x_base)) - s * longint'(row) + c * longint'(col);
    py = longint'($signed(k.y_base)) + c * longint'(row) + s * longint'(col);
    xlim = longint'(k.src_width);
    if (xlim > MaxDim) xlim = MaxDim;
    xlim = xlim * Q16One;
    ylim = longint'(k.src_height);
    if (ylim > MaxDim) ylim = MaxDim;
    ylim = ylim * Q16One;
    res = '0;
    if (px < 0 || py < 0 || px >= xlim || py >= ylim) begin
      res.use_bg = 1'b1;
      return res;
    end
    case (k.bytes_per_pixel)
      3'd1, 3'd2, 3'd4: begin
        size = longint'(k.bytes_per_pixel);
      end
      default: begin
        size = 3;
      end
    endcase
    px = px >> FracW;
    py = py >> FracW;
    offs = py * k.row_pitch + px * size;
    res.col = px[CoordW-1:0];
    res.row = py[CoordW-1:0];
    res.offs = offs[OffsW-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(MaxDim + 1, (1 << DimW) - 1);
    return $urandom_range(1, MaxDim);
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    dir_row_t dr;
    dr.is_cfg = 1'b1;
    dr.idx = idx;
    dr.data = data;
    dr.col = '0;
    dr.row = '0;
    dr.typed = 1'b0;
    dr.want = '0;
    return dr;
  endfunction

  function automatic dir_row_t pix_row(int col, int row);
    dir_row_t dr;
    dr.is_cfg = 1'b0;
    dr.idx = CfgSrcWidth;
    dr.data = '0;
    dr.col = CoordW'(col);
    dr.row = CoordW'(row);
    dr.typed = 1'b0;
    dr.want = '0;
    return dr;
  endfunction

  function automatic dir_row_t pix_chk(int col, int row, bit bg, int src_c, int src_r,
                                       int offs);
    dir_row_t dr;
    dr = pix_row(col, row);
    dr.typed = 1'b1;
    dr.want = {bg, CoordW'(src_c), CoordW'(src_r), OffsW'(offs)};
    return dr;
  endfunction

  task automatic end_burst();
    if (in_bus.valid) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    end_burst();
    while (src_addr_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [CoordW-1:0] col, logic [CoordW-1:0] row, bit typed,
                            pix_res_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.dest_col <= col;
    in_bus.dest_row <= row;
    typed_pending = typed;
    typed_want = want;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic run_phase(int p);
    longint w, h, s, c, xb, yb, pitch, bpp, span, w_eff, h_eff;
    longint vals[8];
    real ang;
    int wdt;
    logic [CfgDataW-1:0] d, mask;
    logic [CoordW-1:0] col, row;
    drain();
    idle_on = (p % 4 != 3) && (p != PressurePhase);
    w = pick_dim();
    h = pick_dim();
    ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    s = longint'(65536.0 * $sin(ang));
    c = longint'(65536.0 * $cos(ang));
    if ($urandom_range(0, 9) == 0) begin
      s = longint'($urandom_range(0, (1 << TrigW) - 1)) + TrigMin;
      c = longint'($urandom_range(0, (1 << TrigW) - 1)) + TrigMin;
    end
    pitch = $urandom_range(1, 16384);
    if ($urandom_range(0, 9) == 0) pitch = 0;
    else if ($urandom_range(0, 9) == 0) pitch = $urandom_range(16385, (1 << PitchW) - 1);
    bpp = $urandom_range(0, (1 << BppW) - 1);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 64);
    if (p == 0) begin
      w = MaxDim;
      h = MaxDim;
      s = 0;
      c = Q16One;
      pitch = 16384;
      bpp = 4;
      span = MaxDim;
    end else if (p == 1) begin
      w = 1;
      h = 1;
      pitch = 1;
      bpp = 1;
      span = 2;
    end else if (p == 2) begin
      w = (1 << DimW) - 1;
      h = (1 << DimW) - 1;
      s = TrigMin;
      c = -TrigMin - 1;
      pitch = (1 << PitchW) - 1;
      bpp = 7;
    end
    // Aim the center of the destination window at the center of the source.
    w_eff = (w > MaxDim) ? MaxDim : w;
    h_eff = (h > MaxDim) ? MaxDim : h;
    xb = w_eff * (Q16One / 2) - (c - s) * (span - 1) / 2
         + longint'($urandom_range(0, 65535)) - 32768;
    yb = h_eff * (Q16One / 2) - (c + s) * (span - 1) / 2
         + longint'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 7) == 0) xb = longint'(int'($urandom()));
    if ($urandom_range(0, 7) == 0) yb = longint'(int'($urandom()));
    if (p == 3) begin
      xb = BaseMin;
      yb = BaseMax;
    end
    if (xb > BaseMax) xb = BaseMax;
    if (xb < BaseMin) xb = BaseMin;
    if (yb > BaseMax) yb = BaseMax;
    if (yb < BaseMin) yb = BaseMin;
    vals = '{w, h, s, c, xb, yb, pitch, bpp};
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_e'(i))
        CfgSrcWidth, CfgSrcHeight: wdt = DimW;
        CfgSin, CfgCos:            wdt = TrigW;
        CfgRowPitch:               wdt = PitchW;
        CfgBpp:                    wdt = BppW;
        default:                   wdt = BaseW;
      endcase
      d = vals[i][CfgDataW-1:0];
      // Bits above the register width are don't-care; fill them at random half the time.
      if (wdt < CfgDataW && $urandom_range(0, 1) == 1) begin
        mask = (CfgDataW'(1) << wdt) - 1;
        d = (d & mask) | ($urandom() & ~mask);
      end
      write_reg(cfg_idx_e'(i), d);
    end
    if (p == PressurePhase) hold_req = 1'b1;
    for (int n = 0; n < ItemsPerPhase; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        col = CoordW'($urandom_range(0, int'(span) - 1));
        row = CoordW'($urandom_range(0, int'(span) - 1));
      end else begin
        col = CoordW'($urandom_range(0, MaxDim - 1));
        row = CoordW'($urandom_range(0, MaxDim - 1));
      end
      send_pixel(col, row, 1'b0, '0);
    end
    end_burst();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Every accepted beat is mirrored here: register writes, predictions, result checks.
  always @(posedge clk_i) begin
    pix_res_t got, want;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_idx_e'(cfg_bus.index))
          CfgSrcWidth:  cfg_mirror.src_width = cfg_bus.data[DimW-1:0];
          CfgSrcHeight: cfg_mirror.src_height = cfg_bus.data[DimW-1:0];
          CfgSin:       cfg_mirror.sin_q16 = cfg_bus.data[TrigW-1:0];
          CfgCos:       cfg_mirror.cos_q16 = cfg_bus.data[TrigW-1:0];
          CfgXBase:     cfg_mirror.x_base = cfg_bus.data[BaseW-1:0];
          CfgYBase:     cfg_mirror.y_base = cfg_bus.data[BaseW-1:0];
          CfgRowPitch:  cfg_mirror.row_pitch = cfg_bus.data[PitchW-1:0];
          CfgBpp:       cfg_mirror.bytes_per_pixel = cfg_bus.data[BppW-1:0];
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (typed_pending) src_addr_q.push_back(typed_want);
        else src_addr_q.push_back(map_pixel(cfg_mirror, in_bus.dest_col, in_bus.dest_row));
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.use_background, out_bus.src_col, out_bus.src_row, out_bus.byte_offset};
        if (src_addr_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= MaxReports)
            $display("%0t: result beat with nothing expected: bg %0b col %0d row %0d offset %0d",
                     $time, got.use_bg, got.col, got.row, got.offs);
        end else begin
          want = src_addr_q.pop_front();
          if (got.use_bg !== want.use_bg || got.col !== want.col || got.row !== want.row ||
              got.offs !== want.offs) begin
            mism_cnt++;
            if (mism_cnt <= MaxReports)
              $display("%0t: mismatch (exp/act) bg %0b/%0b col %0d/%0d row %0d/%0d offset %0d/%0d",
                       $time, want.use_bg, got.use_bg, want.col, got.col, want.row, got.row,
                       want.offs, got.offs);
          end
        end
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      out_bus.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : watchdog
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < WatchLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("tb_rotate_nearest_source_address: errors");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.dest_col = '0;
    in_bus.dest_row = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CfgSrcWidth;
    cfg_bus.data = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    typed_pending = 1'b0;
    typed_want = '0;
    mism_cnt = 0;
    cfg_mirror.src_width = 1;
    cfg_mirror.src_height = 1;
    cfg_mirror.sin_q16 = 0;
    cfg_mirror.cos_q16 = TrigW'(Q16One);
    cfg_mirror.x_base = 0;
    cfg_mirror.y_base = 0;
    cfg_mirror.row_pitch = 4096;
    cfg_mirror.bytes_per_pixel = 4;

    // Default settings: a single source pixel under the identity rotation.
    dir_tab.push_back(pix_chk(0, 0, 0, 0, 0, 0));
    dir_tab.push_back(pix_chk(1, 0, 1, 0, 0, 0));
    dir_tab.push_back(pix_chk(0, 1, 1, 0, 0, 0));
    dir_tab.push_back(pix_chk(4095, 4095, 1, 0, 0, 0));
    dir_tab.push_back(cfg_row(CfgSrcWidth, 4096));
    dir_tab.push_back(cfg_row(CfgSrcHeight, 4096));
    dir_tab.push_back(cfg_row(CfgRowPitch, 16384));
    dir_tab.push_back(pix_chk(4095, 4095, 0, 4095, 4095, 67108860));
    dir_tab.push_back(pix_chk(4095, 0, 0, 4095, 0, 16380));
    dir_tab.push_back(pix_chk(0, 4095, 0, 0, 4095, 67092480));
    dir_tab.push_back(pix_row(2730, 1365));
    // Pixel sizes other than 1, 2 and 4 count as three bytes.
    dir_tab.push_back(cfg_row(CfgBpp, 3));
    dir_tab.push_back(pix_chk(1, 1, 0, 1, 1, 16387));
    dir_tab.push_back(cfg_row(CfgBpp, 0));
    dir_tab.push_back(pix_row(5, 7));
    dir_tab.push_back(cfg_row(CfgBpp, 7));
    dir_tab.push_back(pix_row(4095, 4095));
    // A pitch above 16384 can make the offset wrap.
    dir_tab.push_back(cfg_row(CfgRowPitch, 32767));
    dir_tab.push_back(cfg_row(CfgBpp, 2));
    dir_tab.push_back(pix_row(4095, 4095));
    dir_tab.push_back(pix_row(0, 2048));
    dir_tab.push_back(cfg_row(CfgSrcWidth, 0));
    dir_tab.push_back(pix_chk(0, 0, 1, 0, 0, 0));
    // Extents above the maximum saturate.
    dir_tab.push_back(cfg_row(CfgSrcWidth, 8191));
    dir_tab.push_back(cfg_row(CfgSrcHeight, 8191));
    dir_tab.push_back(pix_row(4095, 4095));
    dir_tab.push_back(pix_row(4095, 100));
    dir_tab.push_back(cfg_row(CfgSin, 32'h0001_0000));
    dir_tab.push_back(cfg_row(CfgCos, 32'h0000_0000));
    dir_tab.push_back(cfg_row(CfgXBase, 32'h0FFF_0000));
    dir_tab.push_back(pix_row(0, 0));
    dir_tab.push_back(pix_row(4095, 4095));
    dir_tab.push_back(pix_row(0, 4095));
    // Sine and cosine near plus and minus two.
    dir_tab.push_back(cfg_row(CfgSin, 32'h0002_0000));
    dir_tab.push_back(cfg_row(CfgCos, 32'h0001_FFFF));
    dir_tab.push_back(cfg_row(CfgXBase, 32'h0000_0000));
    dir_tab.push_back(cfg_row(CfgYBase, 32'h0FFF_0000));
    dir_tab.push_back(pix_row(100, 0));
    dir_tab.push_back(pix_row(2047, 2047));
    dir_tab.push_back(cfg_row(CfgXBase, 32'h7FFF_FFFF));
    dir_tab.push_back(cfg_row(CfgYBase, 32'h8000_0000));
    dir_tab.push_back(pix_row(4095, 0));
    dir_tab.push_back(pix_row(0, 4095));

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].col, dir_tab[i].row, dir_tab[i].typed, dir_tab[i].want);
      end
    end
    end_burst();

    for (int p = 0; p < NumPhases; p++) run_phase(p);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mism_cnt == 0 && src_addr_q.size() == 0) begin
      $display("tb_rotate_nearest_source_address: clean");
    end else begin
      $display("tb_rotate_nearest_source_address: errors");
    end
    $finish;
  end

endmodule
